// ===== hdl/cpr_pkg.sv =====
// shared types, command/status bundles and constants for the clock page replacer
package cpr_pkg;

  localparam int VADDR_W    = 32;
  localparam int PAGE_SHIFT = 12;
  localparam int CFG_W      = 7;
  localparam int VPAGE_W    = 20;
  localparam int FIDX_W     = 6;
  localparam int CNT_W      = 32;
  localparam int NUM_CNT    = 4;

  // statistics counter slots
  localparam int CNT_ACCESS    = 0;
  localparam int CNT_MISS      = 1;
  localparam int CNT_WRITEBACK = 2;
  localparam int CNT_DROP      = 3;

  typedef struct packed {
    logic [VADDR_W-1:0] vaddr;
    logic               is_write;
  } cpr_in_t;

  typedef struct packed {
    logic               hit;
    logic               evicted;
    logic [VPAGE_W-1:0] victim_page;
    logic               victim_dirty;
    logic [FIDX_W-1:0]  frame_index;
    logic [CNT_W-1:0]   access_count;
    logic [CNT_W-1:0]   miss_count;
    logic [CNT_W-1:0]   writeback_count;
    logic [CNT_W-1:0]   drop_count;
  } cpr_out_t;

  // controller to datapath
  typedef struct packed {
    logic capture;     // latch the accepted word
    logic resolve;     // act on the registered tag match
    logic sweep_step;  // clear reference bit under the hand and advance
    logic commit;      // fill or replace the frame under the hand
    logic load_out;    // move the finished result to the output register
  } cpr_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic hit;
    logic ref_at_hand;
  } cpr_status_t;

endpackage

// ===== hdl/cpr_ctrl.sv =====
// sequencing state machine and handshake control for the clock page replacer
module cpr_ctrl
  import cpr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  output logic        out_valid,
  input  logic        out_stall,
  input  cpr_status_t status,
  output cpr_cmd_t    cmd
);

  typedef enum logic [5:0] {
    ST_IDLE    = 6'b000001,
    ST_MATCH   = 6'b000010,
    ST_RESOLVE = 6'b000100,
    ST_SWEEP   = 6'b001000,
    ST_VICTIM  = 6'b010000,
    ST_DONE    = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || !out_stall;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_MATCH;
        end
      end
      ST_MATCH: begin
        state_nxt = ST_RESOLVE;
      end
      ST_RESOLVE: begin
        cmd.resolve = 1'b1;
        state_nxt   = status.hit ? ST_DONE : ST_SWEEP;
      end
      ST_SWEEP: begin
        if (status.ref_at_hand) begin
          cmd.sweep_step = 1'b1;
        end else begin
          state_nxt = ST_VICTIM;
        end
      end
      ST_VICTIM: begin
        cmd.commit = 1'b1;
        state_nxt  = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // output valid flag
  always_comb begin
    priority if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== hdl/cpr_datapath.sv =====
// frame tag store, per-frame flags, clock hand, counters and result registers
module cpr_datapath
  import cpr_pkg::*;
#(
  parameter int FRAMES    = 64,
  parameter int PAGE_BITS = 20
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata,
  input  cpr_in_t          in_word,
  input  cpr_cmd_t         cmd,
  output cpr_status_t      status,
  output cpr_out_t         out_word
);

  localparam int FW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int CW = $clog2(FRAMES + 1);

  logic [CFG_W-1:0]     frames_in_use_r;
  logic [CW-1:0]        n_act;
  logic [PAGE_BITS-1:0] page_r;
  logic                 wr_r;
  logic [PAGE_BITS-1:0] tag_cam [FRAMES];
  logic [PAGE_BITS-1:0] tag_ram [FRAMES];
  logic [PAGE_BITS-1:0] rd_q;
  logic [FRAMES-1:0]    occ_r, ref_r, dirty_r;
  logic [FRAMES-1:0]    match_nxt, match_r;
  logic [FW-1:0]        hand_r, sweep_h_r;
  logic [FW-1:0]        hand_start, sweep_h_next, hit_idx;
  logic [CW-1:0]        sweep_h_inc;
  logic [CNT_W-1:0]     cnt_r [NUM_CNT];
  logic                 vic_evict, vic_dirty;
  cpr_out_t             hit_res, miss_res, res_r, out_word_r;

  // frame count register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frames_in_use_r <= CFG_W'(64);
    end else if (cfg_we) begin
      frames_in_use_r <= cfg_wdata;
    end
  end

  // managed frame count clamped to 1..FRAMES
  always_comb begin
    priority if (frames_in_use_r == '0) begin
      n_act = CW'(1);
    end else if (32'(frames_in_use_r) > 32'(FRAMES)) begin
      n_act = CW'(FRAMES);
    end else begin
      n_act = CW'(frames_in_use_r);
    end
  end

  // accepted word
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      page_r <= PAGE_BITS'(in_word.vaddr[VADDR_W-1:PAGE_SHIFT]);
      wr_r   <= in_word.is_write;
    end
  end

  // parallel tag compare over managed frames
  always_comb begin
    for (int i = 0; i < FRAMES; i++) begin
      match_nxt[i] = occ_r[i] && (tag_cam[i] == page_r) && (CW'(i) < n_act);
    end
  end

  always_ff @(posedge clk) begin
    match_r <= match_nxt;
  end

  // lowest matching frame wins
  always_comb begin
    hit_idx = '0;
    for (int i = FRAMES - 1; i >= 0; i--) begin
      if (match_r[i]) begin
        hit_idx = FW'(i);
      end
    end
  end

  // hand arithmetic
  assign hand_start   = (CW'(hand_r) >= n_act) ? '0 : hand_r;
  assign sweep_h_inc  = CW'(sweep_h_r) + CW'(1);
  assign sweep_h_next = (sweep_h_inc == n_act) ? '0 : FW'(sweep_h_inc);

  assign status.hit         = |match_r;
  assign status.ref_at_hand = ref_r[sweep_h_r];

  // tag compare copy, one register per frame
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      tag_cam[sweep_h_r] <= page_r;
    end
  end

  // tag memory for victim readout, read under the sweep position
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      tag_ram[sweep_h_r] <= page_r;
    end
    rd_q <= tag_ram[sweep_h_r];
  end

  assign vic_evict = occ_r[sweep_h_r];
  assign vic_dirty = vic_evict && dirty_r[sweep_h_r];

  // frame flags, hand and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r     <= '0;
      ref_r     <= '0;
      dirty_r   <= '0;
      hand_r    <= '0;
      sweep_h_r <= '0;
      for (int i = 0; i < NUM_CNT; i++) begin
        cnt_r[i] <= '0;
      end
    end else begin
      if (cmd.resolve) begin
        cnt_r[CNT_ACCESS] <= cnt_r[CNT_ACCESS] + CNT_W'(1);
        if (status.hit) begin
          ref_r[hit_idx] <= 1'b1;
          if (wr_r) begin
            dirty_r[hit_idx] <= 1'b1;
          end
        end else begin
          cnt_r[CNT_MISS] <= cnt_r[CNT_MISS] + CNT_W'(1);
          sweep_h_r       <= hand_start;
        end
      end
      if (cmd.sweep_step) begin
        ref_r[sweep_h_r] <= 1'b0;
        sweep_h_r        <= sweep_h_next;
      end
      if (cmd.commit) begin
        occ_r[sweep_h_r]   <= 1'b1;
        ref_r[sweep_h_r]   <= 1'b1;
        dirty_r[sweep_h_r] <= wr_r;
        hand_r             <= sweep_h_next;
        if (vic_evict && vic_dirty) begin
          cnt_r[CNT_WRITEBACK] <= cnt_r[CNT_WRITEBACK] + CNT_W'(1);
        end
        if (vic_evict && !vic_dirty) begin
          cnt_r[CNT_DROP] <= cnt_r[CNT_DROP] + CNT_W'(1);
        end
      end
    end
  end

  // hit result, counted with this access
  always_comb begin
    hit_res                 = '0;
    hit_res.hit             = 1'b1;
    hit_res.frame_index     = FIDX_W'(hit_idx);
    hit_res.access_count    = cnt_r[CNT_ACCESS] + CNT_W'(1);
    hit_res.miss_count      = cnt_r[CNT_MISS];
    hit_res.writeback_count = cnt_r[CNT_WRITEBACK];
    hit_res.drop_count      = cnt_r[CNT_DROP];
  end

  // miss result, access and miss already counted at resolve
  always_comb begin
    miss_res                 = '0;
    miss_res.evicted         = vic_evict;
    miss_res.victim_page     = vic_evict ? VPAGE_W'(rd_q) : '0;
    miss_res.victim_dirty    = vic_dirty;
    miss_res.frame_index     = FIDX_W'(sweep_h_r);
    miss_res.access_count    = cnt_r[CNT_ACCESS];
    miss_res.miss_count      = cnt_r[CNT_MISS];
    miss_res.writeback_count = cnt_r[CNT_WRITEBACK] + CNT_W'(vic_dirty);
    miss_res.drop_count      = cnt_r[CNT_DROP] + CNT_W'(vic_evict && !vic_dirty);
  end

  // finished result, then output word
  always_ff @(posedge clk) begin
    if (cmd.resolve && status.hit) begin
      res_r <= hit_res;
    end else if (cmd.commit) begin
      res_r <= miss_res;
    end
    if (cmd.load_out) begin
      out_word_r <= res_r;
    end
  end

  assign out_word = out_word_r;

endmodule

// ===== hdl/clock_page_replacer.sv =====
// top level of the clock (second chance) page replacement unit
//
// Input channel in_valid/in_stall/in_word carries one access word: a 32-bit
// virtual address (page number in bits 31..12) and a write flag. Output
// channel out_valid/out_stall/out_word returns one result word per access:
// hit, eviction details, the frame now holding the page and four wrapping
// statistics counters. cfg_we/cfg_wdata set the managed frame count (reset 64);
// write it only while no access is in flight.
// A hit passes through the match and resolve states to the result register; a
// miss also runs the clock sweep, which clears at most the managed frame count
// of reference bits and visits one frame per cycle, and then the victim commit.
// An access is taken only while the controller is idle; the output register
// lets the next access start while a result waits on out_stall. A stalled
// result holds its word; the block stalls input once its own result register
// is full and the output is still stalled.
// Synchronous active-low reset empties all frames, clears the hand, the
// counters and out_valid, and restores the frame count to 64. No clearing pass.
module clock_page_replacer
  import cpr_pkg::*;
#(
  parameter int FRAMES    = 64,
  parameter int PAGE_BITS = 20
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata,
  input  logic             in_valid,
  output logic             in_stall,
  input  cpr_in_t          in_word,
  output logic             out_valid,
  input  logic             out_stall,
  output cpr_out_t         out_word
);

  cpr_cmd_t    cmd;
  cpr_status_t status;

  // sequencing
  cpr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // storage and arithmetic
  cpr_datapath #(
    .FRAMES    (FRAMES),
    .PAGE_BITS (PAGE_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_word   (in_word),
    .cmd       (cmd),
    .status    (status),
    .out_word  (out_word)
  );

endmodule

// ===== hdl/cpr_checker.sv =====
// port-level checks for the clock page replacer, bound to the top level
module cpr_checker
  import cpr_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_stall,
  input logic     out_valid,
  input logic     out_stall,
  input cpr_out_t out_word
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("stalled output word changed");

  // one access at a time: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted on consecutive cycles");

  // a hit never reports an eviction
  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.hit |->
      !out_word.evicted && !out_word.victim_dirty && (out_word.victim_page == '0))
    else $error("hit result carries eviction data");

  // victim fields are zero without an eviction
  a_no_evict_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_word.evicted |->
      !out_word.victim_dirty && (out_word.victim_page == '0))
    else $error("victim data without eviction");

  // reset empties the output
  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind clock_page_replacer cpr_checker u_cpr_checker (.*);
